>>> sv/particle_step_bezier_speed_assert.svh
// Assertion macros used by the particle integrator RTL.
`ifndef PARTICLE_STEP_BEZIER_SPEED_ASSERT_SVH
`define PARTICLE_STEP_BEZIER_SPEED_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PSBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("particle integrator assertion failed");
`define PSBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("particle integrator assertion failed");
`else
`define PSBS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PSBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/psbs_pkg.sv
// Package with types and constants of the particle integrator.
package psbs_pkg;

    localparam logic [15:0] FRAME_TIME_RESET = 16'd1092;
    localparam int          T_W              = 17;
    localparam logic [16:0] T_ONE            = 17'h10000;
    localparam int          R_W              = 25;
    localparam int          DIV_STEPS        = 3;
    localparam int          DIV_STAGES       = 6;
    localparam int          DIV_DEPTH        = DIV_STAGES + 1;
    localparam int          Q_W              = DIV_STAGES * DIV_STEPS;
    localparam int          CURVE_DEPTH      = 7;
    localparam int          MOVE_DEPTH       = 2;

    typedef logic [23:0]        age_t;
    typedef logic signed [23:0] curve_t;
    typedef logic signed [31:0] fix32_t;

    typedef struct packed {
        age_t   age;
        logic   expired;
        logic   last;
        fix32_t pos_x;
        fix32_t pos_y;
        fix32_t vel_x;
        fix32_t vel_y;
    } side_t;

    typedef struct packed {
        curve_t y0;
        curve_t y1;
        curve_t y2;
        curve_t y3;
    } ctrl_pts_t;

    typedef struct packed {
        side_t            side;
        ctrl_pts_t        pts;
        logic             life_zero;
        logic [Q_W-1:0]   quot;
    } div_out_t;

    typedef struct packed {
        side_t  side;
        curve_t speed;
    } curve_out_t;

endpackage

>>> sv/psbs_if.sv
// Channel interfaces for particle words, result words and configuration writes.
interface psbs_in_if;
    logic                    valid;
    logic                    ready;
    logic [23:0]             age_in;
    logic [23:0]             life_span;
    logic signed [23:0]      curve_y0;
    logic signed [23:0]      curve_y1;
    logic signed [23:0]      curve_y2;
    logic signed [23:0]      curve_y3;
    logic signed [31:0]      vel_x;
    logic signed [31:0]      vel_y;
    logic signed [31:0]      pos_x_in;
    logic signed [31:0]      pos_y_in;
    logic                    last_in;

    modport source (
        output valid, age_in, life_span, curve_y0, curve_y1, curve_y2, curve_y3,
               vel_x, vel_y, pos_x_in, pos_y_in, last_in,
        input  ready
    );
    modport sink (
        input  valid, age_in, life_span, curve_y0, curve_y1, curve_y2, curve_y3,
               vel_x, vel_y, pos_x_in, pos_y_in, last_in,
        output ready
    );
endinterface

interface psbs_out_if;
    logic               valid;
    logic               ready;
    logic [23:0]        age_out;
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic               expired;
    logic               last_out;

    modport source (
        output valid, age_out, pos_x_out, pos_y_out, expired, last_out,
        input  ready
    );
    modport sink (
        input  valid, age_out, pos_x_out, pos_y_out, expired, last_out,
        output ready
    );
endinterface

interface psbs_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] frame_time;

    modport source (
        output valid, frame_time,
        input  ready
    );
    modport sink (
        input  valid, frame_time,
        output ready
    );
endinterface

>>> sv/particle_step_bezier_speed.sv
// Top level of the particle integrator with a cubic Bezier speed curve.
// The block takes one particle word per clock while the output side is not stalled and
// returns one result word for each, in order. The path runs through the quotient pipeline
// (six stages of three restoring steps after the age add), seven stages of Bernstein
// weights, curve products and sum, and two stages of velocity scaling and saturating
// position update; the last of these is the output register. Each stage holds its word
// while the next one is full, so empty slots fill up during a stall and input is taken as
// long as any slot ahead is free. The frame time register is always ready for a write and
// is read by each particle word as it is accepted.
`include "particle_step_bezier_speed_assert.svh"

module particle_step_bezier_speed (
    input  logic       clk,
    input  logic       rst_n,
    psbs_in_if.sink    item,
    psbs_cfg_if.sink   cfg,
    psbs_out_if.source result
);

    logic [15:0]          frame_time_reg;
    logic [15:0]          frame_time_next;
    logic                 div_valid;
    logic                 div_ready;
    psbs_pkg::div_out_t   div_data;
    logic                 curve_valid;
    logic                 curve_ready;
    psbs_pkg::curve_out_t curve_data;

    assign cfg.ready       = 1'b1;
    assign frame_time_next = cfg.valid ? cfg.frame_time : frame_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_time_reg <= psbs_pkg::FRAME_TIME_RESET;
        end
        else
        begin
            frame_time_reg <= frame_time_next;
        end
    end

    psbs_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_time (frame_time_reg),
        .item       (item),
        .out_valid  (div_valid),
        .out_ready  (div_ready),
        .out_data   (div_data)
    );

    psbs_curve u_curve (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_data   (div_data),
        .out_valid (curve_valid),
        .out_ready (curve_ready),
        .out_data  (curve_data)
    );

    psbs_move u_move (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (curve_valid),
        .in_ready (curve_ready),
        .in_data  (curve_data),
        .result   (result)
    );

    `PSBS_ASSERT_NEXT(a_cfg_write, clk, rst_n, cfg.valid && cfg.ready, frame_time_reg == $past(cfg.frame_time))
    `PSBS_ASSERT_IMPL(a_t_range, clk, rst_n, div_valid && !div_data.side.expired && !div_data.life_zero, div_data.quot[psbs_pkg::Q_W-1:1] <= psbs_pkg::T_ONE)
    `PSBS_ASSERT_IMPL(a_expired_age, clk, rst_n, result.valid && result.expired, result.age_out != '0)

endmodule

>>> sv/psbs_div.sv
// Age update and pipelined restoring divider that forms the normalized time.
module psbs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        frame_time,
    psbs_in_if.sink            item,
    output logic               out_valid,
    input  logic               out_ready,
    output psbs_pkg::div_out_t out_data
);

    typedef struct packed {
        psbs_pkg::side_t              side;
        psbs_pkg::ctrl_pts_t          pts;
        psbs_pkg::age_t               life;
        logic                         life_zero;
        logic [psbs_pkg::R_W-1:0]     rem;
        logic [psbs_pkg::Q_W-1:0]     quot;
    } div_stage_t;

    function automatic div_stage_t div_step(div_stage_t s);
        div_stage_t               o;
        logic [psbs_pkg::R_W-1:0] r;
        logic [psbs_pkg::R_W-1:0] diff;
        logic                     bit_q;
        o = s;
        r = s.rem;
        for (int k = 0; k < psbs_pkg::DIV_STEPS; k++)
        begin
            bit_q  = r >= {1'b0, s.life};
            diff   = r - {1'b0, s.life};
            if (bit_q)
            begin
                r = diff;
            end
            o.quot = {o.quot[psbs_pkg::Q_W-2:0], bit_q};
            r      = {r[psbs_pkg::R_W-2:0], 1'b0};
        end
        o.rem = r;
        return o;
    endfunction

    logic [psbs_pkg::DIV_DEPTH-1:0] vld_reg;
    logic [psbs_pkg::DIV_DEPTH-1:0] vld_next;
    logic [psbs_pkg::DIV_DEPTH:0]   rdy;
    div_stage_t                     st_reg [psbs_pkg::DIV_DEPTH];
    div_stage_t                     first_next;
    logic [24:0]                    age_sum;
    psbs_pkg::age_t                 age_sat;

    always_comb
    begin
        rdy[psbs_pkg::DIV_DEPTH] = out_ready;
        for (int i = psbs_pkg::DIV_DEPTH - 1; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign item.ready = rdy[0];
    assign vld_next   = {vld_reg[psbs_pkg::DIV_DEPTH-2:0], item.valid};

    always_comb
    begin
        age_sum                 = 25'(item.age_in) + 25'(frame_time);
        age_sat                 = age_sum[24] ? '1 : age_sum[23:0];
        first_next.side.age     = age_sat;
        first_next.side.expired = age_sat > item.life_span;
        first_next.side.last    = item.last_in;
        first_next.side.pos_x   = item.pos_x_in;
        first_next.side.pos_y   = item.pos_y_in;
        first_next.side.vel_x   = item.vel_x;
        first_next.side.vel_y   = item.vel_y;
        first_next.pts.y0       = item.curve_y0;
        first_next.pts.y1       = item.curve_y1;
        first_next.pts.y2       = item.curve_y2;
        first_next.pts.y3       = item.curve_y3;
        first_next.life         = item.life_span;
        first_next.life_zero    = item.life_span == '0;
        first_next.rem          = {1'b0, age_sat};
        first_next.quot         = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < psbs_pkg::DIV_DEPTH; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            st_reg[0] <= first_next;
        end
        for (int i = 1; i < psbs_pkg::DIV_DEPTH; i++)
        begin
            if (rdy[i])
            begin
                st_reg[i] <= div_step(st_reg[i-1]);
            end
        end
    end

    assign out_valid          = vld_reg[psbs_pkg::DIV_DEPTH-1];
    assign out_data.side      = st_reg[psbs_pkg::DIV_DEPTH-1].side;
    assign out_data.pts       = st_reg[psbs_pkg::DIV_DEPTH-1].pts;
    assign out_data.life_zero = st_reg[psbs_pkg::DIV_DEPTH-1].life_zero;
    assign out_data.quot      = st_reg[psbs_pkg::DIV_DEPTH-1].quot;

endmodule

>>> sv/psbs_curve.sv
// Bernstein weight and speed curve pipeline.
module psbs_curve (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  psbs_pkg::div_out_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output psbs_pkg::curve_out_t out_data
);

    typedef struct packed {
        psbs_pkg::side_t     side;
        psbs_pkg::ctrl_pts_t pts;
        logic [16:0]         t;
        logic [16:0]         u;
    } c0_t;

    typedef struct packed {
        psbs_pkg::side_t     side;
        psbs_pkg::ctrl_pts_t pts;
        logic [16:0]         t;
        logic [16:0]         u;
        logic [32:0]         u2;
        logic [32:0]         t2;
    } c1_t;

    typedef struct packed {
        psbs_pkg::side_t     side;
        psbs_pkg::ctrl_pts_t pts;
        logic [48:0]         p0;
        logic [48:0]         p1;
        logic [48:0]         p2;
        logic [48:0]         p3;
    } c2_t;

    typedef struct packed {
        psbs_pkg::side_t     side;
        psbs_pkg::ctrl_pts_t pts;
        logic [32:0]         w0;
        logic [32:0]         w1;
        logic [32:0]         w2;
        logic [32:0]         w3;
    } c3_t;

    typedef struct packed {
        psbs_pkg::side_t    side;
        logic signed [57:0] m0;
        logic signed [57:0] m1;
        logic signed [57:0] m2;
        logic signed [57:0] m3;
    } c4_t;

    typedef struct packed {
        psbs_pkg::side_t    side;
        logic signed [58:0] s01;
        logic signed [58:0] s23;
    } c5_t;

    logic [psbs_pkg::CURVE_DEPTH-1:0] vld_reg;
    logic [psbs_pkg::CURVE_DEPTH-1:0] vld_next;
    logic [psbs_pkg::CURVE_DEPTH:0]   rdy;

    c0_t                  c0_reg, c0_next;
    c1_t                  c1_reg, c1_next;
    c2_t                  c2_reg, c2_next;
    c3_t                  c3_reg, c3_next;
    c4_t                  c4_reg, c4_next;
    c5_t                  c5_reg, c5_next;
    psbs_pkg::curve_out_t c6_reg, c6_next;

    logic [33:0]          u2_full;
    logic [33:0]          t2_full;
    logic [49:0]          p0_full;
    logic [49:0]          p1_full;
    logic [49:0]          p2_full;
    logic [49:0]          p3_full;
    logic [50:0]          p1x3;
    logic [50:0]          p2x3;
    logic signed [59:0]   acc;

    always_comb
    begin
        rdy[psbs_pkg::CURVE_DEPTH] = out_ready;
        for (int i = psbs_pkg::CURVE_DEPTH - 1; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign in_ready = rdy[0];
    assign vld_next = {vld_reg[psbs_pkg::CURVE_DEPTH-2:0], in_valid};

    always_comb
    begin
        c0_next.side = in_data.side;
        c0_next.pts  = in_data.pts;
        c0_next.t    = in_data.life_zero ? psbs_pkg::T_ONE : in_data.quot[psbs_pkg::Q_W-1:1];
        c0_next.u    = psbs_pkg::T_ONE - c0_next.t;

        u2_full      = 34'(c0_reg.u) * 34'(c0_reg.u);
        t2_full      = 34'(c0_reg.t) * 34'(c0_reg.t);
        c1_next.side = c0_reg.side;
        c1_next.pts  = c0_reg.pts;
        c1_next.t    = c0_reg.t;
        c1_next.u    = c0_reg.u;
        c1_next.u2   = u2_full[32:0];
        c1_next.t2   = t2_full[32:0];

        p0_full      = 50'(c1_reg.u2) * 50'(c1_reg.u);
        p1_full      = 50'(c1_reg.u2) * 50'(c1_reg.t);
        p2_full      = 50'(c1_reg.t2) * 50'(c1_reg.u);
        p3_full      = 50'(c1_reg.t2) * 50'(c1_reg.t);
        c2_next.side = c1_reg.side;
        c2_next.pts  = c1_reg.pts;
        c2_next.p0   = p0_full[48:0];
        c2_next.p1   = p1_full[48:0];
        c2_next.p2   = p2_full[48:0];
        c2_next.p3   = p3_full[48:0];

        p1x3         = 51'({c2_reg.p1, 1'b0}) + 51'(c2_reg.p1);
        p2x3         = 51'({c2_reg.p2, 1'b0}) + 51'(c2_reg.p2);
        c3_next.side = c2_reg.side;
        c3_next.pts  = c2_reg.pts;
        c3_next.w0   = c2_reg.p0[48:16];
        c3_next.w1   = p1x3[48:16];
        c3_next.w2   = p2x3[48:16];
        c3_next.w3   = c2_reg.p3[48:16];

        c4_next.side = c3_reg.side;
        c4_next.m0   = 58'(c3_reg.pts.y0) * 58'($signed({1'b0, c3_reg.w0}));
        c4_next.m1   = 58'(c3_reg.pts.y1) * 58'($signed({1'b0, c3_reg.w1}));
        c4_next.m2   = 58'(c3_reg.pts.y2) * 58'($signed({1'b0, c3_reg.w2}));
        c4_next.m3   = 58'(c3_reg.pts.y3) * 58'($signed({1'b0, c3_reg.w3}));

        c5_next.side = c4_reg.side;
        c5_next.s01  = 59'(c4_reg.m0) + 59'(c4_reg.m1);
        c5_next.s23  = 59'(c4_reg.m2) + 59'(c4_reg.m3);

        // The sum is rounded half up to Q8.16 by adding one half before the floor.
        acc           = 60'(c5_reg.s01) + 60'(c5_reg.s23) + (60'sd1 <<< 31);
        c6_next.side  = c5_reg.side;
        c6_next.speed = acc[55:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < psbs_pkg::CURVE_DEPTH; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            c0_reg <= c0_next;
        end
        if (rdy[1])
        begin
            c1_reg <= c1_next;
        end
        if (rdy[2])
        begin
            c2_reg <= c2_next;
        end
        if (rdy[3])
        begin
            c3_reg <= c3_next;
        end
        if (rdy[4])
        begin
            c4_reg <= c4_next;
        end
        if (rdy[5])
        begin
            c5_reg <= c5_next;
        end
        if (rdy[6])
        begin
            c6_reg <= c6_next;
        end
    end

    assign out_valid = vld_reg[psbs_pkg::CURVE_DEPTH-1];
    assign out_data  = c6_reg;

endmodule

>>> sv/psbs_move.sv
// Velocity scaling, rounding and saturating position update with the result register.
module psbs_move (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  psbs_pkg::curve_out_t in_data,
    psbs_out_if.source           result
);

    typedef struct packed {
        psbs_pkg::side_t    side;
        logic signed [55:0] prod_x;
        logic signed [55:0] prod_y;
    } m0_t;

    typedef struct packed {
        psbs_pkg::age_t   age;
        psbs_pkg::fix32_t pos_x;
        psbs_pkg::fix32_t pos_y;
        logic             expired;
        logic             last;
    } m1_t;

    // Rounding of the step is folded into the position add: pos * 2^16 + half + product.
    function automatic psbs_pkg::fix32_t move_axis(psbs_pkg::fix32_t pos,
                                                   logic signed [55:0] prod);
        logic signed [57:0] sum;
        logic signed [41:0] res;
        psbs_pkg::fix32_t   o;
        sum = 58'($signed({pos, 16'h8000})) + 58'(prod);
        res = sum[57:16];
        if (res > 42'sd2147483647)
        begin
            o = 32'sh7FFFFFFF;
        end
        else if (res < -42'sd2147483648)
        begin
            o = 32'sh80000000;
        end
        else
        begin
            o = res[31:0];
        end
        return o;
    endfunction

    logic [psbs_pkg::MOVE_DEPTH-1:0] vld_reg;
    logic [psbs_pkg::MOVE_DEPTH-1:0] vld_next;
    logic [psbs_pkg::MOVE_DEPTH:0]   rdy;
    m0_t                             m0_reg, m0_next;
    m1_t                             m1_reg, m1_next;

    always_comb
    begin
        rdy[psbs_pkg::MOVE_DEPTH] = result.ready;
        for (int i = psbs_pkg::MOVE_DEPTH - 1; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign in_ready = rdy[0];
    assign vld_next = {vld_reg[psbs_pkg::MOVE_DEPTH-2:0], in_valid};

    always_comb
    begin
        m0_next.side    = in_data.side;
        m0_next.prod_x  = 56'(in_data.side.vel_x) * 56'(in_data.speed);
        m0_next.prod_y  = 56'(in_data.side.vel_y) * 56'(in_data.speed);

        m1_next.age     = m0_reg.side.age;
        m1_next.expired = m0_reg.side.expired;
        m1_next.last    = m0_reg.side.last;
        if (m0_reg.side.expired)
        begin
            m1_next.pos_x = m0_reg.side.pos_x;
            m1_next.pos_y = m0_reg.side.pos_y;
        end
        else
        begin
            m1_next.pos_x = move_axis(m0_reg.side.pos_x, m0_reg.prod_x);
            m1_next.pos_y = move_axis(m0_reg.side.pos_y, m0_reg.prod_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < psbs_pkg::MOVE_DEPTH; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            m0_reg <= m0_next;
        end
        if (rdy[1])
        begin
            m1_reg <= m1_next;
        end
    end

    assign result.valid     = vld_reg[psbs_pkg::MOVE_DEPTH-1];
    assign result.age_out   = m1_reg.age;
    assign result.pos_x_out = m1_reg.pos_x;
    assign result.pos_y_out = m1_reg.pos_y;
    assign result.expired   = m1_reg.expired;
    assign result.last_out  = m1_reg.last;

endmodule

>>> bench/tb_particle_step_bezier_speed.sv
// Self-checking testbench for the cubic Bezier speed particle integrator.
module tb_particle_step_bezier_speed;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int             CYCLE_LIMIT  = 200000;
    localparam int             DRAIN_CYCLES = 32;
    localparam psbs_pkg::age_t AGE_FULL     = 24'hFFFFFF;
    localparam longint         T_UNITY      = 64'sd65536;
    localparam longint         SPEED_ROUND  = 64'sd2147483648;
    localparam longint         MOVE_ROUND   = 64'sd32768;
    localparam longint         POS_MAX      = 64'sd2147483647;
    localparam longint         POS_MIN      = -64'sd2147483648;

    typedef struct {
        psbs_pkg::age_t   age;
        psbs_pkg::age_t   life;
        psbs_pkg::curve_t y0;
        psbs_pkg::curve_t y1;
        psbs_pkg::curve_t y2;
        psbs_pkg::curve_t y3;
        psbs_pkg::fix32_t vel_x;
        psbs_pkg::fix32_t vel_y;
        psbs_pkg::fix32_t pos_x;
        psbs_pkg::fix32_t pos_y;
        logic             last;
    } particle_t;

    typedef struct {
        psbs_pkg::age_t   age;
        psbs_pkg::fix32_t pos_x;
        psbs_pkg::fix32_t pos_y;
        logic             expired;
        logic             last;
    } step_result_t;

    logic clk;
    logic rst_n;

    psbs_in_if  item_ch();
    psbs_out_if result_ch();
    psbs_cfg_if cfg_ch();

    particle_step_bezier_speed DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .cfg    (cfg_ch),
        .result (result_ch)
    );

    step_result_t pending_steps[$];
    logic [15:0]  frame_time_now;
    logic         no_idle;
    int           mismatch_count;
    int           cycle_count;
    particle_t    seen_particle;
    step_result_t got_step;
    step_result_t want_step;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic psbs_pkg::fix32_t move_axis(psbs_pkg::fix32_t pos,
                                                   psbs_pkg::fix32_t vel, longint speed);
        longint sum;
        sum = longint'(pos) + ((longint'(vel) * speed + MOVE_ROUND) >>> 16);
        if (sum > POS_MAX)
        begin
            return psbs_pkg::fix32_t'(POS_MAX);
        end
        if (sum < POS_MIN)
        begin
            return psbs_pkg::fix32_t'(POS_MIN);
        end
        return psbs_pkg::fix32_t'(sum);
    endfunction

    function automatic step_result_t advance_particle(particle_t p, logic [15:0] ft);
        step_result_t r;
        logic [24:0]  age_sum;
        logic [63:0]  scaled_age;
        longint       t;
        longint       u;
        longint       w0;
        longint       w1;
        longint       w2;
        longint       w3;
        longint       acc;
        longint       speed;
        age_sum   = {1'b0, p.age} + {9'd0, ft};
        r.age     = age_sum[24] ? AGE_FULL : age_sum[23:0];
        r.expired = r.age > p.life;
        r.pos_x   = p.pos_x;
        r.pos_y   = p.pos_y;
        r.last    = p.last;
        if (!r.expired)
        begin
            if (p.life == 24'd0)
            begin
                t = T_UNITY;
            end
            else
            begin
                scaled_age = {40'd0, r.age} << 16;
                t = longint'(scaled_age / {40'd0, p.life});
                if (t > T_UNITY)
                begin
                    t = T_UNITY;
                end
            end
            u  = T_UNITY - t;
            w0 = (u * u * u) >>> 16;
            w1 = (3 * u * u * t) >>> 16;
            w2 = (3 * u * t * t) >>> 16;
            w3 = (t * t * t) >>> 16;
            acc = longint'(p.y0) * w0 + longint'(p.y1) * w1
                + longint'(p.y2) * w2 + longint'(p.y3) * w3;
            speed = (acc + SPEED_ROUND) >>> 32;
            if (speed != 0)
            begin
                r.pos_x = move_axis(p.pos_x, p.vel_x, speed);
                r.pos_y = move_axis(p.pos_y, p.vel_y, speed);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                frame_time_now = cfg_ch.frame_time;
            end
            if (item_ch.valid && item_ch.ready)
            begin
                seen_particle.age   = item_ch.age_in;
                seen_particle.life  = item_ch.life_span;
                seen_particle.y0    = item_ch.curve_y0;
                seen_particle.y1    = item_ch.curve_y1;
                seen_particle.y2    = item_ch.curve_y2;
                seen_particle.y3    = item_ch.curve_y3;
                seen_particle.vel_x = item_ch.vel_x;
                seen_particle.vel_y = item_ch.vel_y;
                seen_particle.pos_x = item_ch.pos_x_in;
                seen_particle.pos_y = item_ch.pos_y_in;
                seen_particle.last  = item_ch.last_in;
                pending_steps.push_back(advance_particle(seen_particle, frame_time_now));
            end
            if (result_ch.valid && result_ch.ready)
            begin
                got_step.age     = result_ch.age_out;
                got_step.pos_x   = result_ch.pos_x_out;
                got_step.pos_y   = result_ch.pos_y_out;
                got_step.expired = result_ch.expired;
                got_step.last    = result_ch.last_out;
                if (pending_steps.size() == 0)
                begin
                    report_mismatch("word with nothing expected, age", got_step.age, 0);
                end
                else
                begin
                    want_step = pending_steps.pop_front();
                    if (got_step.age !== want_step.age)
                    begin
                        report_mismatch("age_out", got_step.age, want_step.age);
                    end
                    if (got_step.pos_x !== want_step.pos_x)
                    begin
                        report_mismatch("pos_x_out", got_step.pos_x, want_step.pos_x);
                    end
                    if (got_step.pos_y !== want_step.pos_y)
                    begin
                        report_mismatch("pos_y_out", got_step.pos_y, want_step.pos_y);
                    end
                    if (got_step.expired !== want_step.expired)
                    begin
                        report_mismatch("expired", got_step.expired, want_step.expired);
                    end
                    if (got_step.last !== want_step.last)
                    begin
                        report_mismatch("last_out", got_step.last, want_step.last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        result_ch.ready <= no_idle || ($urandom_range(99) >= 8);
    end

    function automatic particle_t make_particle(psbs_pkg::age_t age, psbs_pkg::age_t life,
                                                psbs_pkg::curve_t y0, psbs_pkg::curve_t y1,
                                                psbs_pkg::curve_t y2, psbs_pkg::curve_t y3,
                                                psbs_pkg::fix32_t vx, psbs_pkg::fix32_t vy,
                                                psbs_pkg::fix32_t px, psbs_pkg::fix32_t py,
                                                logic last);
        particle_t p;
        p.age   = age;
        p.life  = life;
        p.y0    = y0;
        p.y1    = y1;
        p.y2    = y2;
        p.y3    = y3;
        p.vel_x = vx;
        p.vel_y = vy;
        p.pos_x = px;
        p.pos_y = py;
        p.last  = last;
        return p;
    endfunction

    function automatic psbs_pkg::curve_t random_curve();
        logic signed [17:0] narrow;
        narrow = 18'($urandom);
        if ($urandom_range(3) == 0)
        begin
            return psbs_pkg::curve_t'($urandom);
        end
        return psbs_pkg::curve_t'(narrow);
    endfunction

    function automatic psbs_pkg::fix32_t random_velocity();
        logic signed [19:0] narrow;
        narrow = 20'($urandom);
        if ($urandom_range(3) == 0)
        begin
            return psbs_pkg::fix32_t'($urandom);
        end
        return psbs_pkg::fix32_t'(narrow);
    endfunction

    function automatic particle_t random_particle(logic [15:0] ft);
        particle_t p;
        int        kind;
        kind   = $urandom_range(99);
        p.life = psbs_pkg::age_t'($urandom);
        if ($urandom_range(4) == 0)
        begin
            p.life = p.life >> $urandom_range(23);
        end
        if (kind < 75 && p.life >= {8'd0, ft})
        begin
            p.age = psbs_pkg::age_t'($urandom_range(0, int'(p.life) - int'(ft)));
        end
        else
        begin
            p.age = psbs_pkg::age_t'($urandom);
        end
        p.y0    = random_curve();
        p.y1    = random_curve();
        p.y2    = random_curve();
        p.y3    = random_curve();
        p.vel_x = random_velocity();
        p.vel_y = random_velocity();
        p.pos_x = psbs_pkg::fix32_t'($urandom);
        p.pos_y = psbs_pkg::fix32_t'($urandom);
        p.last  = 1'($urandom);
        return p;
    endfunction

    task automatic send_particle(input particle_t p);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < 8)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.age_in    <= p.age;
        item_ch.life_span <= p.life;
        item_ch.curve_y0  <= p.y0;
        item_ch.curve_y1  <= p.y1;
        item_ch.curve_y2  <= p.y2;
        item_ch.curve_y3  <= p.y3;
        item_ch.vel_x     <= p.vel_x;
        item_ch.vel_y     <= p.vel_y;
        item_ch.pos_x_in  <= p.pos_x;
        item_ch.pos_y_in  <= p.pos_y;
        item_ch.last_in   <= p.last;
        do
        begin
            @(posedge clk);
        end
        while (!item_ch.ready);
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_steps.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic set_frame_time(input logic [15:0] value);
        wait_until_drained();
        @(negedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.frame_time <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_reset_frame_time();
        send_particle(make_particle(24'd0, 24'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
                                    32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0));
        send_particle(make_particle(24'd0, AGE_FULL, 24'sh7FFFFF, 24'sh010000, 24'sh020000,
                                    24'sh030000, 32'sh00010000, -32'sh00010000, 32'sd0,
                                    32'sd0, 1'b1));
        send_particle(make_particle(AGE_FULL, AGE_FULL, 24'sh100000, 24'sh0, 24'sh0,
                                    24'sh020000, 32'sh00020000, 32'sh00030000,
                                    32'sh12345678, -32'sh12345678, 1'b0));
        send_particle(make_particle(24'hFFFF00, 24'd0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                                    24'sh7FFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                    32'sh55555555, -32'sh55555555, 1'b1));
        send_particle(make_particle(24'd1000, 24'd2092, 24'sh0, 24'sh0, 24'sh0, 24'sh018000,
                                    32'sh00040000, -32'sh00040000, 32'sd7, -32'sd7, 1'b0));
        send_particle(make_particle(24'd500, 24'd3000, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
                                    32'sh7FFFFFFF, 32'sh80000000, 32'sd100, 32'sd200, 1'b0));
        send_particle(make_particle(24'd0, 24'd100000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                                    24'sh7FFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                                    32'sh7FFF0000, 32'sh80000000, 1'b1));
        send_particle(make_particle(24'd40000, 24'd80000, 24'sh800000, 24'sh800000,
                                    24'sh800000, 24'sh800000, 32'sh7FFFFFFF, 32'sh80000000,
                                    32'sd0, 32'sd0, 1'b0));
        send_particle(make_particle(24'd30000, 24'd62184, 24'sh010000, -24'sh020000,
                                    24'sh030000, -24'sh010000, 32'sh00000001, -32'sh00000001,
                                    32'sh7FFFFFFF, 32'sh80000000, 1'b1));
    endtask

    task automatic test_zero_frame_time();
        set_frame_time(16'd0);
        send_particle(make_particle(24'd0, 24'd0, 24'sh7FFFFF, 24'sh0, 24'sh0, 24'sh020000,
                                    32'sh00030000, -32'sh00050000, 32'sd1, 32'sd2, 1'b0));
        send_particle(make_particle(24'd0, 24'd0, 24'sh0, 24'sh0, 24'sh0, 24'sh800000,
                                    32'sh7FFFFFFF, 32'sh80000000, 32'sd0, -32'sd1, 1'b1));
        send_particle(make_particle(24'd5, 24'd4, 24'sh010000, 24'sh010000, 24'sh010000,
                                    24'sh010000, 32'sh00010000, 32'sh00010000, 32'sd9,
                                    32'sd9, 1'b0));
        send_particle(make_particle(AGE_FULL, AGE_FULL, -24'sh000001, 24'sh000001,
                                    -24'sh000001, 24'sh000001, 32'sh00100000,
                                    32'sh00100000, 32'sd0, 32'sd0, 1'b1));
        send_particle(make_particle(24'd0, 24'd1, 24'sh000001, 24'sh0, 24'sh0, 24'sh0,
                                    32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sd0, 32'sd0, 1'b0));
    endtask

    task automatic test_max_frame_time();
        set_frame_time(16'hFFFF);
        send_particle(make_particle(AGE_FULL, AGE_FULL, 24'sh050000, 24'sh0, 24'sh0,
                                    24'sh030000, 32'sh00010000, 32'sh00010000, 32'sd0,
                                    32'sd0, 1'b0));
        send_particle(make_particle(24'hFF0001, AGE_FULL, 24'sh010000, 24'sh020000,
                                    24'sh030000, 24'sh040000, -32'sh00020000,
                                    32'sh00020000, 32'sd5, 32'sd5, 1'b1));
        send_particle(make_particle(24'd0, 24'h00FFFF, 24'sh010000, 24'sh010000, 24'sh010000,
                                    24'sh010000, 32'sh00010000, -32'sh00010000, 32'sd0,
                                    32'sd0, 1'b0));
        send_particle(make_particle(24'd0, 24'h00FFFE, 24'sh010000, 24'sh010000, 24'sh010000,
                                    24'sh010000, 32'sh00010000, -32'sh00010000, 32'sd0,
                                    32'sd0, 1'b1));
        send_particle(make_particle(24'h001234, 24'h1FFFFF, -24'sh400000, 24'sh400000,
                                    -24'sh400000, 24'sh400000, 32'sh0FFFFFFF,
                                    -32'sh0FFFFFFF, 32'sh7F000000, 32'sh81000000, 1'b0));
    endtask

    task automatic test_random_stream(input logic [15:0] ft, input int count,
                                      input int steady_count);
        set_frame_time(ft);
        for (int n = 0; n < count; n++)
        begin
            no_idle = n < steady_count;
            send_particle(random_particle(ft));
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n             = 1'b0;
        no_idle           = 1'b0;
        mismatch_count    = 0;
        cycle_count       = 0;
        frame_time_now    = psbs_pkg::FRAME_TIME_RESET;
        item_ch.valid     = 1'b0;
        item_ch.age_in    = '0;
        item_ch.life_span = '0;
        item_ch.curve_y0  = '0;
        item_ch.curve_y1  = '0;
        item_ch.curve_y2  = '0;
        item_ch.curve_y3  = '0;
        item_ch.vel_x     = '0;
        item_ch.vel_y     = '0;
        item_ch.pos_x_in  = '0;
        item_ch.pos_y_in  = '0;
        item_ch.last_in   = 1'b0;
        result_ch.ready   = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.frame_time = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_frame_time();
        test_zero_frame_time();
        test_max_frame_time();
        test_random_stream(psbs_pkg::FRAME_TIME_RESET, 200, 150);
        test_random_stream(16'($urandom), 170, 0);
        test_random_stream(16'd0, 110, 0);
        test_random_stream(16'hFFFF, 110, 0);
        test_random_stream(16'($urandom_range(1, 4096)), 110, 0);

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (pending_steps.size() != 0)
        begin
            want_step = pending_steps.pop_front();
            report_mismatch("word never returned, age", -1, want_step.age);
        end
        if (mismatch_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
